### src/dme_pkg.sv
package dme_pkg;

  localparam int TYPE_W  = 4;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [TYPE_W-1:0] TYPE_LINE = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_QUAD = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_TRI  = 4'd4;

endpackage

### src/duplicate_mesh_element_marker.sv
// Requests of the target type scan the stored entries in order and stop at the first match;
// other types go straight to the result. One request is handled at a time.
// One table entry is compared per cycle.
// The input side takes the next request while a finished result waits on the output.
// Reset (rst, synchronous): clears entry count, match count and output valid, sets
// target_type to 4. Table contents are not cleared; only written entries are ever read.
module duplicate_mesh_element_marker #(
  parameter int MAX_ELEMENTS = 256,
  parameter int NODE_BITS    = 20,
  localparam int DATA_W = ((4 * NODE_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dme_pkg::TYPE_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [DATA_W-1:0]           s_tdata,   // node_a, node_b, node_c, node_d
  input  logic [dme_pkg::TYPE_W:0]    s_tuser,   // start_run, elem_type
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dme_pkg::COUNT_W-1:0] m_tdata,   // dup_count
  output logic [1:0]                  m_tuser    // is_doubled, table_overflow
);

  localparam int ENTRY_W = 4 * NODE_BITS;
  localparam int AW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                      state;
  logic [dme_pkg::TYPE_W-1:0]  target_type;
  logic [ENTRY_W-1:0]          cur;
  logic                        cur_match;
  logic                        doubled;
  logic [CNT_W-1:0]            stored;
  logic [CNT_W-1:0]            idx;
  logic                        cmp_valid;
  logic [dme_pkg::COUNT_W-1:0] count;

  logic [ENTRY_W-1:0]          rd_data;
  logic [2:0]                  cmp_n;
  logic                        issue;
  logic                        full;
  logic                        out_free;
  logic                        ram_we;
  logic                        type_ok;
  logic [dme_pkg::TYPE_W-1:0]  in_type;
  logic [dme_pkg::COUNT_W:0]   sum;

  function automatic logic [2:0] count_patterns(input logic [dme_pkg::TYPE_W-1:0] typ,
                                                input logic [ENTRY_W-1:0] e,
                                                input logic [ENTRY_W-1:0] c);
    logic [NODE_BITS-1:0] e0, e1, e2, e3, c0, c1, c2, c3;
    logic [2:0] n;
    e0 = e[0*NODE_BITS +: NODE_BITS];
    e1 = e[1*NODE_BITS +: NODE_BITS];
    e2 = e[2*NODE_BITS +: NODE_BITS];
    e3 = e[3*NODE_BITS +: NODE_BITS];
    c0 = c[0*NODE_BITS +: NODE_BITS];
    c1 = c[1*NODE_BITS +: NODE_BITS];
    c2 = c[2*NODE_BITS +: NODE_BITS];
    c3 = c[3*NODE_BITS +: NODE_BITS];
    unique case (typ)
      dme_pkg::TYPE_LINE: begin
        n = {2'b00, (e0 == c0 && e1 == c1)} + {2'b00, (e0 == c1 && e1 == c0)};
      end
      dme_pkg::TYPE_TRI: begin
        n = {2'b00, (e0 == c0 && e1 == c1 && e2 == c2)}
          + {2'b00, (e0 == c0 && e1 == c2 && e2 == c1)}
          + {2'b00, (e0 == c1 && e1 == c2 && e2 == c0)}
          + {2'b00, (e0 == c1 && e1 == c0 && e2 == c2)}
          + {2'b00, (e0 == c2 && e1 == c0 && e2 == c1)}
          + {2'b00, (e0 == c2 && e1 == c1 && e2 == c0)};
      end
      dme_pkg::TYPE_QUAD: begin
        n = {2'b00, ((e0 == c0 && e1 == c1 && e2 == c2 && e3 == c3) ||
                     (e0 == c1 && e1 == c2 && e2 == c3 && e3 == c0) ||
                     (e0 == c2 && e1 == c3 && e2 == c0 && e3 == c1) ||
                     (e0 == c3 && e1 == c0 && e2 == c1 && e3 == c2))};
      end
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  assign in_type = s_tuser[dme_pkg::TYPE_W:1];

  always_comb begin
    unique case (target_type) inside
      dme_pkg::TYPE_LINE, dme_pkg::TYPE_QUAD, dme_pkg::TYPE_TRI: begin
        type_ok = (in_type == target_type);
      end
      default: type_ok = 1'b0;
    endcase
  end

  assign s_tready = (state == IDLE);
  assign issue    = (idx < stored);
  assign full     = (stored == CNT_FULL);
  assign out_free = !m_tvalid || m_tready;
  assign ram_we   = (state == DONE) && out_free && cur_match && !full;
  assign cmp_n    = count_patterns(target_type, rd_data, cur);
  assign sum      = {1'b0, count} + (dme_pkg::COUNT_W + 1)'(cmp_n);

  dme_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored[AW-1:0]),
    .wdata (cur),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      target_type <= dme_pkg::TYPE_TRI;
      stored      <= '0;
      count       <= '0;
      cmp_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_type <= cfg_data;
      end
      if (state == DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            cur       <= s_tdata[ENTRY_W-1:0];
            cur_match <= type_ok;
            doubled   <= 1'b0;
            idx       <= '0;
            cmp_valid <= 1'b0;
            if (s_tuser[0]) begin
              stored <= '0;
              count  <= '0;
            end
            state <= type_ok ? SCAN : DONE;
          end
        end
        SCAN: begin
          if (cmp_valid && cmp_n != 3'd0) begin
            doubled   <= 1'b1;
            count     <= sum[dme_pkg::COUNT_W] ? dme_pkg::COUNT_MAX : sum[dme_pkg::COUNT_W-1:0];
            cmp_valid <= 1'b0;
            state     <= DONE;
          end else begin
            cmp_valid <= issue;
            if (issue) begin
              idx <= idx + 1'b1;
            end else if (!cmp_valid) begin
              state <= DONE;
            end
          end
        end
        DONE: begin
          if (out_free) begin
            m_tdata  <= count;
            m_tuser  <= {cur_match && full, doubled};
            if (cur_match && !full) begin
              stored <= stored + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### src/dme_ram.sv
module dme_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dme_checker.sv
module dme_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [dme_pkg::COUNT_W-1:0] m_tdata,
  input logic [1:0]                  m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_doubled_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata != '0)
    else $error("doubled element with zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind duplicate_mesh_element_marker dme_checker u_dme_checker (.*);

### bench/duplicate_mesh_element_marker_test.sv
module duplicate_mesh_element_marker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 256;
  localparam int NODE_W       = 20;
  localparam int DATA_W       = 4 * NODE_W;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 110;
  localparam int REPEAT_ITEMS = 250;
  localparam int FULL_ITEMS   = 20;

  typedef logic [dme_pkg::TYPE_W-1:0]  type_code_t;
  typedef logic [dme_pkg::COUNT_W-1:0] count_t;
  typedef logic [DATA_W-1:0]           elem_nodes_t;

  // type codes with no meaning to the block
  localparam type_code_t TYPE_NONE = 4'h0;
  localparam type_code_t TYPE_TOP  = 4'hF;

  localparam type_code_t PHASE_TARGET [PHASES] =
    '{dme_pkg::TYPE_TRI, dme_pkg::TYPE_LINE, dme_pkg::TYPE_QUAD,
      dme_pkg::TYPE_LINE, dme_pkg::TYPE_QUAD, dme_pkg::TYPE_TRI};

  class dup_board;
    typedef struct {
      bit     doubled;
      count_t count;
      bit     overflow;
    } verdict_t;

    verdict_t    due[$];
    elem_nodes_t mesh[TABLE_DEPTH];
    int unsigned stored;
    int unsigned total;
    type_code_t  target;
    int          errors;

    function new();
      stored = 0;
      total  = 0;
      target = dme_pkg::TYPE_TRI;
      errors = 0;
    endfunction

    function void set_target(type_code_t v);
      target = v;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function int unsigned patterns(type_code_t t, elem_nodes_t e, elem_nodes_t c);
      int unsigned       n;
      logic [NODE_W-1:0] p[4];
      logic [NODE_W-1:0] q[4];
      n = 0;
      for (int k = 0; k < 4; k++) begin
        p[k] = e[k*NODE_W +: NODE_W];
        q[k] = c[k*NODE_W +: NODE_W];
      end
      case (t)
        dme_pkg::TYPE_LINE: begin
          if (p[0] == q[0] && p[1] == q[1]) n++;
          if (p[0] == q[1] && p[1] == q[0]) n++;
        end
        dme_pkg::TYPE_TRI: begin
          if (p[0] == q[0] && p[1] == q[1] && p[2] == q[2]) n++;
          if (p[0] == q[0] && p[1] == q[2] && p[2] == q[1]) n++;
          if (p[0] == q[1] && p[1] == q[2] && p[2] == q[0]) n++;
          if (p[0] == q[1] && p[1] == q[0] && p[2] == q[2]) n++;
          if (p[0] == q[2] && p[1] == q[0] && p[2] == q[1]) n++;
          if (p[0] == q[2] && p[1] == q[1] && p[2] == q[0]) n++;
        end
        dme_pkg::TYPE_QUAD: begin
          for (int r = 0; r < 4; r++) begin
            if (n == 0 && p[0] == q[r] && p[1] == q[(r+1)%4] &&
                p[2] == q[(r+2)%4] && p[3] == q[(r+3)%4])
              n = 1;
          end
        end
        default: ;
      endcase
      return n;
    endfunction

    function void note_request(bit start, type_code_t t, elem_nodes_t c);
      verdict_t    v;
      int unsigned n;
      v.doubled  = 0;
      v.overflow = 0;
      if (start) begin
        stored = 0;
        total  = 0;
      end
      if (t == target && (t == dme_pkg::TYPE_LINE || t == dme_pkg::TYPE_QUAD ||
                          t == dme_pkg::TYPE_TRI)) begin
        for (int i = 0; i < stored; i++) begin
          n = patterns(t, mesh[i], c);
          if (n != 0) begin
            v.doubled = 1;
            total += n;
            if (total > dme_pkg::COUNT_MAX) total = dme_pkg::COUNT_MAX;
            break;
          end
        end
        if (stored < TABLE_DEPTH) begin
          mesh[stored] = c;
          stored++;
        end else begin
          v.overflow = 1;
        end
      end
      v.count = count_t'(total);
      due = {due, v};
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(bit doubled, count_t count, bit overflow);
      verdict_t v;
      if (due.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual dup_count %0d",
                 $time, count);
        errors++;
        return;
      end
      v = due.pop_front();
      if (v.doubled != doubled) report("is_doubled", v.doubled, doubled);
      if (v.count != count) report("dup_count", v.count, count);
      if (v.overflow != overflow) report("table_overflow", v.overflow, overflow);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  type_code_t                 cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [DATA_W-1:0]          s_tdata;   // node_a, node_b, node_c, node_d
  logic [dme_pkg::TYPE_W:0]   s_tuser;   // start_run, elem_type
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  count_t                     m_tdata;   // dup_count
  logic [1:0]                 m_tuser;   // is_doubled, table_overflow

  dup_board          board = new();
  int                send_idle = 0;
  int                recv_idle = 0;
  int                stall_cycles = 0;
  logic [NODE_W-1:0] pool_base;
  logic [NODE_W-1:0] rep_node;

  duplicate_mesh_element_marker u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random backpressure, checking, watchdog
  always @(posedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= recv_idle);
    if (rst !== 1'b0) begin
      stall_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tuser[0], m_tdata, m_tuser[1]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic elem_nodes_t pack(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                       logic [NODE_W-1:0] c, logic [NODE_W-1:0] d);
    return {d, c, b, a};
  endfunction

  task automatic send_elem(bit start, type_code_t t, elem_nodes_t c);
    while (int'($urandom_range(99)) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= {t, start};
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_request(start, t, c);
  endtask

  task automatic write_target(type_code_t v);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_target(v);
  endtask

  // mostly nodes from a small pool so that duplicates are frequent
  task automatic send_random(type_code_t target);
    bit          start;
    type_code_t  t;
    elem_nodes_t c;
    int          sel;
    start = ($urandom_range(29) == 0);
    t = ($urandom_range(99) < 85) ? target : type_code_t'($urandom_range(15));
    for (int k = 0; k < 4; k++) begin
      sel = $urandom_range(99);
      if (sel < 70) c[k*NODE_W +: NODE_W] = pool_base ^ NODE_W'($urandom_range(3));
      else if (sel < 95) c[k*NODE_W +: NODE_W] = NODE_W'($urandom);
      else if (sel < 97) c[k*NODE_W +: NODE_W] = '0;
      else c[k*NODE_W +: NODE_W] = '1;
    end
    send_elem(start, t, c);
  endtask

  initial begin
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // triangles and other element types under the reset target
    send_elem(1, dme_pkg::TYPE_TRI, pack(1, 2, 3, 0));
    send_elem(0, dme_pkg::TYPE_TRI, pack(3, 1, 2, 0));
    send_elem(0, dme_pkg::TYPE_TRI, pack(2, 1, 3, '1));
    send_elem(0, dme_pkg::TYPE_TRI, pack('1, 0, '1, 0));
    send_elem(0, dme_pkg::TYPE_TRI, pack(5, 5, 5, 0));
    send_elem(0, dme_pkg::TYPE_TRI, pack(5, 5, 5, 7));
    send_elem(0, dme_pkg::TYPE_LINE, pack(9, 9, 0, 0));
    send_elem(0, TYPE_TOP, pack('1, '1, '1, '1));
    send_elem(0, TYPE_NONE, pack(1, 2, 3, 0));

    // lines; stored triangles stay in the table
    write_target(dme_pkg::TYPE_LINE);
    send_elem(0, dme_pkg::TYPE_LINE, pack(2, 1, 0, 0));
    send_elem(0, dme_pkg::TYPE_LINE, pack(7, 8, 0, 0));
    send_elem(0, dme_pkg::TYPE_LINE, pack(8, 7, 0, 0));
    send_elem(0, dme_pkg::TYPE_LINE, pack(6, 6, 0, 0));
    send_elem(0, dme_pkg::TYPE_LINE, pack(6, 6, 0, 0));

    // quads: rotation matches, reversal does not
    write_target(dme_pkg::TYPE_QUAD);
    send_elem(1, dme_pkg::TYPE_QUAD, pack(10, 11, 12, 13));
    send_elem(0, dme_pkg::TYPE_QUAD, pack(12, 13, 10, 11));
    send_elem(0, dme_pkg::TYPE_QUAD, pack(13, 12, 11, 10));
    send_elem(0, dme_pkg::TYPE_QUAD, pack('1, '1, '1, '1));
    send_elem(0, dme_pkg::TYPE_QUAD, pack('1, '1, '1, '1));

    // targets with no meaning
    write_target(TYPE_NONE);
    send_elem(0, TYPE_NONE, pack(1, 1, 1, 1));
    write_target(TYPE_TOP);
    send_elem(1, TYPE_TOP, pack(1, 2, 3, 4));
    send_elem(0, dme_pkg::TYPE_TRI, pack(1, 2, 3, 4));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_idle = 13;
        recv_idle = 69;
      end else if (phase < 4) begin
        send_idle = 69;
        recv_idle = 13;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_target(PHASE_TARGET[phase]);
      pool_base = NODE_W'($urandom);
      repeat (PHASE_ITEMS) send_random(PHASE_TARGET[phase]);
    end

    // one triangle repeated, then a full table
    write_target(dme_pkg::TYPE_TRI);
    rep_node = NODE_W'($urandom);
    send_elem(1, dme_pkg::TYPE_TRI, pack(rep_node, rep_node, rep_node, ~rep_node));
    repeat (REPEAT_ITEMS)
      send_elem(0, dme_pkg::TYPE_TRI, pack(rep_node, rep_node, rep_node, NODE_W'($urandom)));
    repeat (FULL_ITEMS)
      send_elem(0, dme_pkg::TYPE_TRI, pack(NODE_W'($urandom), NODE_W'($urandom),
                                           NODE_W'($urandom), NODE_W'($urandom)));

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
